// ----- src/assert_macros.svh -----
// Assertion macros used by the port-level checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge outside reset
`define SAPC_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Implication whose consequent is checked in the cycle after the antecedent
`define SAPC_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ----- src/sapc_pkg.sv -----
// Shared types and constants of the sensor alarm panel
package sapc_pkg;

  localparam logic [3:0] KEY_LAST_DIGIT = 4'd9;
  localparam logic [3:0] KEY_D          = 4'd13;
  localparam logic [3:0] KEY_STAR       = 4'd14;
  localparam logic [3:0] KEY_HASH       = 4'd15;

  localparam logic [2:0] EV_NONE     = 3'd0;
  localparam logic [2:0] EV_DIGIT    = 3'd1;
  localparam logic [2:0] EV_CODE_OK  = 3'd2;
  localparam logic [2:0] EV_CODE_BAD = 3'd3;
  localparam logic [2:0] EV_CLEARED  = 3'd4;
  localparam logic [2:0] EV_DISPLAY  = 3'd5;
  localparam logic [2:0] EV_LISTED   = 3'd6;

  localparam logic [1:0] REG_PIN_CODE       = 2'd0;
  localparam logic [1:0] REG_TEMP_HYST      = 2'd1;
  localparam logic [1:0] REG_GAS_HYST       = 2'd2;
  localparam logic [1:0] REG_TEMP_VALID_MAX = 2'd3;

  localparam logic [15:0] PIN_CODE_RESET       = 16'h1235;
  localparam logic [9:0]  TEMP_HYST_RESET      = 10'd32;
  localparam logic [13:0] GAS_HYST_RESET       = 14'd1280;
  localparam logic [12:0] TEMP_VALID_MAX_RESET = 13'd1280;

  // full-scale factors, all in 1/16 units
  localparam logic [13:0] FULL_TLIM = 14'd192;
  localparam logic [13:0] FULL_GLIM = 14'd12800;
  localparam logic [13:0] FULL_TEMP = 14'd5280;
  localparam logic [13:0] FULL_GAS  = 14'd16000;

  localparam logic [9:0]  TEMP_BASE       = 10'd400;
  localparam logic [12:0] FILT_TEMP_RESET = 13'd400;

  // x / 5 == (x * RECIP5) >> DIV5_SHIFT for x below 2^18
  localparam logic [15:0] RECIP5     = 16'd52429;
  localparam int          DIV5_SHIFT = 18;

  localparam logic [2:0] MAX_LIST = 3'd6;

  localparam int QUEUE_DEPTH = 2;
  localparam int QUEUE_PTR_W = 1;

  typedef struct packed {
    logic [9:0]  temp_hyst;
    logic [13:0] gas_hyst;
    logic [12:0] temp_valid_max;
  } cfg_t;

  typedef struct packed {
    logic [9:0]  temp_limit;
    logic [13:0] gas_limit;
    logic [12:0] filt_temp;
    logic [13:0] filt_gas;
    logic        trip;
    logic        safe;
    logic        key_present;
    logic [3:0]  key_value;
    logic [31:0] now;
  } work_t;

endpackage

// ----- src/sapc_front.sv -----
// Front end: sensor scaling, filtering and threshold classification
module sapc_front import sapc_pkg::*; #(
  parameter int ADC_BITS = 12
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [ADC_BITS-1:0] pot_level,
  input  logic [ADC_BITS-1:0] temp_sample,
  input  logic [ADC_BITS-1:0] gas_sample,
  input  logic                key_present,
  input  logic [3:0]          key_value,
  input  logic [31:0]         now_seconds,
  input  cfg_t                cfg,
  output logic                push,
  output work_t               push_data,
  input  logic                full
);

  localparam int ADC_MAX = (1 << ADC_BITS) - 1;
  localparam int HALF    = (1 << (ADC_BITS - 1)) - 1;
  localparam int PW      = ADC_BITS + 15;
  localparam int SW      = PW - ADC_BITS;
  localparam int WW      = ((SW > ADC_BITS) ? SW : ADC_BITS) + 1;

  localparam logic [2:0] STEP_TLIM = 3'd1;
  localparam logic [2:0] STEP_GLIM = 3'd2;
  localparam logic [2:0] STEP_TRAW = 3'd3;
  localparam logic [2:0] STEP_GRAW = 3'd4;

  typedef enum logic [2:0] {F_IDLE, F_SCALE, F_FILT, F_DIV, F_CLS, F_PUSH} fstate_t;

  // round(p / ADC_MAX) with the half-up bias, by folding 2^N = ADC_MAX + 1
  function automatic logic [13:0] fold(input logic [PW-1:0] p);
    logic [PW-1:0]       pb;
    logic [WW-1:0]       w;
    logic [ADC_BITS:0]   w2;
    logic [WW-1:0]       q;
    pb = p + PW'(HALF);
    w  = WW'(pb[PW-1:ADC_BITS]) + WW'(pb[ADC_BITS-1:0]);
    w2 = (ADC_BITS+1)'(w >> ADC_BITS) + (ADC_BITS+1)'(w[ADC_BITS-1:0]);
    q  = WW'(pb[PW-1:ADC_BITS]) + (w >> ADC_BITS)
       + WW'(w2 >= (ADC_BITS+1)'(ADC_MAX));
    return q[13:0];
  endfunction

  fstate_t             state;
  logic [2:0]          step;
  logic [ADC_BITS-1:0] pot;
  logic [ADC_BITS-1:0] tcode;
  logic [ADC_BITS-1:0] gcode;
  logic                kp;
  logic [3:0]          key;
  logic [31:0]         now;
  logic [PW-1:0]       prod;
  logic [9:0]          tlim;
  logic [13:0]         glim;
  logic [12:0]         raw_t;
  logic [13:0]         raw_g;
  logic [14:0]         sum_t;
  logic [16:0]         sum_g;
  logic [30:0]         prod_t;
  logic [32:0]         prod_g;
  logic [12:0]         ft;
  logic [13:0]         fg;

  logic [ADC_BITS-1:0] code_sel;
  logic [13:0]         full_sel;
  logic [13:0]         fq;
  logic                valid_t;
  logic                tsafe;
  logic                gsafe;
  logic signed [15:0]  tmark;
  logic signed [15:0]  gmark;

  always_comb begin
    case (step)
      3'd0:      begin code_sel = pot;   full_sel = FULL_TLIM; end
      STEP_TLIM: begin code_sel = pot;   full_sel = FULL_GLIM; end
      STEP_GLIM: begin code_sel = tcode; full_sel = FULL_TEMP; end
      STEP_TRAW: begin code_sel = gcode; full_sel = FULL_GAS;  end
      default:   begin code_sel = pot;   full_sel = FULL_TLIM; end
    endcase
  end

  assign fq = fold(prod);

  always_comb begin
    valid_t = ft <= cfg.temp_valid_max;
    tmark   = $signed(16'(tlim)) - $signed(16'(cfg.temp_hyst));
    gmark   = $signed(16'(glim)) - $signed(16'(cfg.gas_hyst));
    tsafe   = !valid_t || ($signed(16'(ft)) < tmark);
    gsafe   = $signed(16'(fg)) < gmark;
  end

  always_comb begin
    push_data.temp_limit  = tlim;
    push_data.gas_limit   = glim;
    push_data.filt_temp   = ft;
    push_data.filt_gas    = fg;
    push_data.trip        = (valid_t && (ft > 13'(tlim))) || (fg > glim);
    push_data.safe        = tsafe && gsafe;
    push_data.key_present = kp;
    push_data.key_value   = key;
    push_data.now         = now;
  end

  assign push     = (state == F_PUSH) && !full;
  assign in_stall = (state != F_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= F_IDLE;
      step  <= '0;
      ft    <= FILT_TEMP_RESET;
      fg    <= '0;
    end else begin
      unique case (state)
        F_IDLE: begin
          if (in_valid) begin
            pot   <= pot_level;
            tcode <= temp_sample;
            gcode <= gas_sample;
            kp    <= key_present;
            key   <= key_value;
            now   <= now_seconds;
            step  <= '0;
            state <= F_SCALE;
          end
        end
        F_SCALE: begin
          prod <= PW'(code_sel) * PW'(full_sel);
          case (step)
            STEP_TLIM: tlim  <= TEMP_BASE + fq[9:0];
            STEP_GLIM: glim  <= fq;
            STEP_TRAW: raw_t <= fq[12:0];
            STEP_GRAW: raw_g <= fq;
            default: ;
          endcase
          step <= step + 3'd1;
          if (step == STEP_GRAW) state <= F_FILT;
        end
        F_FILT: begin
          sum_t <= {ft, 2'b00} + 15'(raw_t) + 15'd2;
          sum_g <= 17'({fg, 2'b00}) + 17'(raw_g) + 17'd2;
          state <= F_DIV;
        end
        F_DIV: begin
          prod_t <= 31'(sum_t) * 31'(RECIP5);
          prod_g <= 33'(sum_g) * 33'(RECIP5);
          state  <= F_CLS;
        end
        F_CLS: begin
          ft    <= prod_t[DIV5_SHIFT +: 13];
          fg    <= prod_g[DIV5_SHIFT +: 14];
          state <= F_PUSH;
        end
        F_PUSH: begin
          if (!full) state <= F_IDLE;
        end
        default: state <= F_IDLE;
      endcase
    end
  end

endmodule

// ----- src/sapc_queue.sv -----
// Two-entry queue between the front end and the back end
module sapc_queue import sapc_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  push,
  input  work_t push_data,
  output logic  full,
  input  logic  pop,
  output work_t pop_data,
  output logic  empty
);

  localparam int QCW = QUEUE_PTR_W + 1;

  work_t                  mem [QUEUE_DEPTH];
  logic [QUEUE_PTR_W-1:0] wr_ptr;
  logic [QUEUE_PTR_W-1:0] rd_ptr;
  logic [QCW-1:0]         count;

  function automatic logic [QUEUE_PTR_W-1:0] ptr_inc(input logic [QUEUE_PTR_W-1:0] p);
    return (p == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  assign full     = (count == QCW'(QUEUE_DEPTH));
  assign empty    = (count == '0);
  assign pop_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        mem[wr_ptr] <= push_data;
        wr_ptr      <= ptr_inc(wr_ptr);
      end
      if (pop) rd_ptr <= ptr_inc(rd_ptr);
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

// ----- src/sapc_back.sv -----
// Back end: alarm, PIN entry, event log and result output
module sapc_back import sapc_pkg::*; #(
  parameter int LOG_DEPTH   = 5,
  parameter int CODE_DIGITS = 4
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        empty,
  input  work_t       pop_data,
  output logic        pop,
  input  logic [15:0] pin_code,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        alarm_on,
  output logic        armed_flag,
  output logic        display_on,
  output logic        alert_raised,
  output logic [2:0]  key_event,
  output logic [9:0]  temp_limit,
  output logic [13:0] gas_limit,
  output logic        entry_valid,
  output logic [31:0] entry_time,
  output logic [12:0] entry_temp,
  output logic [13:0] entry_gas,
  output logic        last
);

  localparam int BW   = 4 * CODE_DIGITS;
  localparam int CW   = $clog2(CODE_DIGITS + 1);
  localparam int NW   = $clog2(LOG_DEPTH + 1);
  localparam int LW   = (LOG_DEPTH > 1) ? $clog2(LOG_DEPTH) : 1;
  localparam int CMPW = (BW > 16) ? BW : 16;

  logic          alarm;
  logic          armed;
  logic          display;
  logic [CW-1:0] dcount;
  logic [BW-1:0] dbuf;
  logic [NW-1:0] lcount;
  logic [31:0]   log_time [LOG_DEPTH];
  logic [12:0]   log_temp [LOG_DEPTH];
  logic [13:0]   log_gas  [LOG_DEPTH];
  logic          list_active;
  logic [2:0]    list_idx;
  logic [2:0]    list_n;

  logic          can_load;
  logic          armed_a;
  logic          raise;
  logic          alarm_next;
  logic          armed_next;
  logic          display_next;
  logic [CW-1:0] dcount_next;
  logic [BW-1:0] dbuf_next;
  logic [NW-1:0] lcount_next;
  logic [2:0]    event_next;
  logic          listing;
  logic          has;
  logic [2:0]    total;
  logic [LW-1:0] list_sel;
  logic          list_end;

  assign can_load = !out_valid || !out_stall;
  assign pop      = !list_active && !empty && can_load;
  assign list_sel = LW'(list_idx);
  assign list_end = (list_idx == list_n - 3'd1);

  always_comb begin
    armed_a      = armed || pop_data.safe;
    raise        = armed_a && !alarm && pop_data.trip;
    alarm_next   = alarm || raise;
    armed_next   = armed_a;
    display_next = display;
    dcount_next  = raise ? '0 : dcount;
    dbuf_next    = raise ? '0 : dbuf;
    lcount_next  = (raise && (lcount < NW'(LOG_DEPTH))) ? lcount + 1'b1 : lcount;
    event_next   = EV_NONE;
    listing      = 1'b0;
    if (pop_data.key_present) begin
      if (pop_data.key_value == KEY_D) begin
        display_next = !display;
        event_next   = EV_DISPLAY;
      end else if (!alarm_next && (pop_data.key_value == KEY_HASH)) begin
        listing    = 1'b1;
        event_next = EV_LISTED;
      end else if (alarm_next) begin
        if (pop_data.key_value <= KEY_LAST_DIGIT) begin
          dbuf_next   = BW'({dbuf_next, pop_data.key_value});
          dcount_next = dcount_next + 1'b1;
          event_next  = EV_DIGIT;
          if (dcount_next == CW'(CODE_DIGITS)) begin
            if (CMPW'(dbuf_next) == CMPW'(pin_code)) begin
              alarm_next = 1'b0;
              armed_next = 1'b0;
              event_next = EV_CODE_OK;
            end else begin
              event_next = EV_CODE_BAD;
            end
            dcount_next = '0;
            dbuf_next   = '0;
          end
        end else if (pop_data.key_value == KEY_STAR) begin
          dcount_next = '0;
          dbuf_next   = '0;
          event_next  = EV_CLEARED;
        end
      end
    end
    has = listing && (lcount_next != '0);
    if (!has) total = 3'd1;
    else if (5'(lcount_next) < 5'(MAX_LIST)) total = 3'(lcount_next);
    else total = MAX_LIST;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid   <= 1'b0;
      list_active <= 1'b0;
      list_idx    <= '0;
      list_n      <= '0;
      alarm       <= 1'b0;
      armed       <= 1'b1;
      display     <= 1'b1;
      dcount      <= '0;
      dbuf        <= '0;
      lcount      <= '0;
    end else begin
      if (list_active) begin
        if (can_load) begin
          out_valid  <= 1'b1;
          entry_time <= log_time[list_sel];
          entry_temp <= log_temp[list_sel];
          entry_gas  <= log_gas[list_sel];
          last       <= list_end;
          list_idx   <= list_idx + 3'd1;
          if (list_end) list_active <= 1'b0;
        end
      end else if (pop) begin
        alarm   <= alarm_next;
        armed   <= armed_next;
        display <= display_next;
        dcount  <= dcount_next;
        dbuf    <= dbuf_next;
        lcount  <= lcount_next;
        if (raise) begin
          for (int i = LOG_DEPTH - 1; i > 0; i--) begin
            log_time[i] <= log_time[i-1];
            log_temp[i] <= log_temp[i-1];
            log_gas[i]  <= log_gas[i-1];
          end
          log_time[0] <= pop_data.now;
          log_temp[0] <= pop_data.filt_temp;
          log_gas[0]  <= pop_data.filt_gas;
        end
        out_valid    <= 1'b1;
        alarm_on     <= alarm_next;
        armed_flag   <= armed_next;
        display_on   <= display_next;
        alert_raised <= raise;
        key_event    <= event_next;
        temp_limit   <= pop_data.temp_limit;
        gas_limit    <= pop_data.gas_limit;
        entry_valid  <= has;
        entry_time   <= has ? log_time[0] : '0;
        entry_temp   <= has ? log_temp[0] : '0;
        entry_gas    <= has ? log_gas[0] : '0;
        last         <= (total == 3'd1);
        if (total != 3'd1) begin
          list_active <= 1'b1;
          list_idx    <= 3'd1;
          list_n      <= total;
        end
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

// ----- src/sensor_alarm_pin_controller.sv -----
// Top level of the sensor alarm panel with PIN disarm
// Channel  Handshake              Payload
// input    in_valid / in_stall    pot_level, temp_sample, gas_sample, key_*, now_seconds
// output   out_valid / out_stall  status flags, key_event, limits, entry_*, last
// config   cfg_write              cfg_index, cfg_data
// Front end: no new transfer until the item is pushed; four products on one shared scaling
//   multiplier followed by the divide-by-5 filter step; in_stall is high meanwhile.
// Back end: one result per cycle unless out_stall holds it, 1 to min(LOG_DEPTH, 6) results
//   per item (5 by default), fed from a two-entry queue.
// Reset: synchronous; the event log is bounded by its fill count, no clearing pass.
// out_stall holds the output register only; the front keeps working until the queue is full.
module sensor_alarm_pin_controller import sapc_pkg::*; #(
  parameter int LOG_DEPTH   = 5,
  parameter int CODE_DIGITS = 4,
  parameter int ADC_BITS    = 12
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [ADC_BITS-1:0] pot_level,
  input  logic [ADC_BITS-1:0] temp_sample,
  input  logic [ADC_BITS-1:0] gas_sample,
  input  logic                key_present,
  input  logic [3:0]          key_value,
  input  logic [31:0]         now_seconds,
  output logic                out_valid,
  input  logic                out_stall,
  output logic                alarm_on,
  output logic                armed_flag,
  output logic                display_on,
  output logic                alert_raised,
  output logic [2:0]          key_event,
  output logic [9:0]          temp_limit,
  output logic [13:0]         gas_limit,
  output logic                entry_valid,
  output logic [31:0]         entry_time,
  output logic [12:0]         entry_temp,
  output logic [13:0]         entry_gas,
  output logic                last,
  input  logic                cfg_write,
  input  logic [1:0]          cfg_index,
  input  logic [15:0]         cfg_data
);

  logic [15:0] pin_code;
  cfg_t        cfg;
  logic        push;
  work_t       push_data;
  logic        full;
  logic        pop;
  work_t       pop_data;
  logic        empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      pin_code           <= PIN_CODE_RESET;
      cfg.temp_hyst      <= TEMP_HYST_RESET;
      cfg.gas_hyst       <= GAS_HYST_RESET;
      cfg.temp_valid_max <= TEMP_VALID_MAX_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_PIN_CODE:       pin_code           <= cfg_data;
        REG_TEMP_HYST:      cfg.temp_hyst      <= cfg_data[9:0];
        REG_GAS_HYST:       cfg.gas_hyst       <= cfg_data[13:0];
        REG_TEMP_VALID_MAX: cfg.temp_valid_max <= cfg_data[12:0];
        default: ;
      endcase
    end
  end

  sapc_front #(
    .ADC_BITS (ADC_BITS)
  ) u_front (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .pot_level   (pot_level),
    .temp_sample (temp_sample),
    .gas_sample  (gas_sample),
    .key_present (key_present),
    .key_value   (key_value),
    .now_seconds (now_seconds),
    .cfg         (cfg),
    .push        (push),
    .push_data   (push_data),
    .full        (full)
  );

  sapc_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .full      (full),
    .pop       (pop),
    .pop_data  (pop_data),
    .empty     (empty)
  );

  sapc_back #(
    .LOG_DEPTH   (LOG_DEPTH),
    .CODE_DIGITS (CODE_DIGITS)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .empty        (empty),
    .pop_data     (pop_data),
    .pop          (pop),
    .pin_code     (pin_code),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .alarm_on     (alarm_on),
    .armed_flag   (armed_flag),
    .display_on   (display_on),
    .alert_raised (alert_raised),
    .key_event    (key_event),
    .temp_limit   (temp_limit),
    .gas_limit    (gas_limit),
    .entry_valid  (entry_valid),
    .entry_time   (entry_time),
    .entry_temp   (entry_temp),
    .entry_gas    (entry_gas),
    .last         (last)
  );

endmodule

// ----- src/sapc_checker.sv -----
// Port-level checker for the sensor alarm panel, bound to the top level
`include "assert_macros.svh"

module sapc_checker import sapc_pkg::*; (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_stall,
  input logic        alarm_on,
  input logic        armed_flag,
  input logic [2:0]  key_event,
  input logic [9:0]  temp_limit,
  input logic        entry_valid,
  input logic [31:0] entry_time,
  input logic [12:0] entry_temp,
  input logic [13:0] entry_gas,
  input logic        last
);

  `SAPC_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && out_stall, out_valid && $stable(entry_time) && $stable(key_event) && $stable(last), "stalled result changed")
  `SAPC_ASSERT(a_entry_zero, clk, rst, !(out_valid && !entry_valid) || (entry_time == 32'd0 && entry_temp == 13'd0 && entry_gas == 14'd0), "entry fields not zero without entry")
  `SAPC_ASSERT(a_entry_listed, clk, rst, !(out_valid && entry_valid) || (key_event == EV_LISTED && !alarm_on), "log entry outside an idle listing")
  `SAPC_ASSERT(a_code_ok, clk, rst, !(out_valid && key_event == EV_CODE_OK) || (!alarm_on && !armed_flag), "correct code left alarm or arm set")
  `SAPC_ASSERT(a_tlimit_range, clk, rst, !out_valid || (temp_limit >= TEMP_BASE && temp_limit <= TEMP_BASE + 10'(FULL_TLIM)), "temperature limit out of range")

endmodule

bind sensor_alarm_pin_controller sapc_checker u_checker (
  .clk         (clk),
  .rst         (rst),
  .out_valid   (out_valid),
  .out_stall   (out_stall),
  .alarm_on    (alarm_on),
  .armed_flag  (armed_flag),
  .key_event   (key_event),
  .temp_limit  (temp_limit),
  .entry_valid (entry_valid),
  .entry_time  (entry_time),
  .entry_temp  (entry_temp),
  .entry_gas   (entry_gas),
  .last        (last)
);
